>>> rtl/gbl_pkg.sv
// Shared types and constants for the GCD-by-LCM-search block.
// Used by the sequencer, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package gbl_pkg;

   localparam int unsigned OPERAND_WIDTH_DEFAULT = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Datapath strobes from the sequencer
   typedef struct packed {
      logic load_operands;
      logic search_step;
      logic mult;
      logic div_step;
      logic load_rsp;
   } ctrl_type;

   // Datapath flags back to the sequencer
   typedef struct packed {
      logic operand_zero;
      logic multiples_equal;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/gcd_by_lcm_search.sv
// GCD-by-LCM-search top level: sequencer plus shared-adder datapath.
// Depends on gbl_pkg, gbl_ctrl and gbl_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Returns gcd(a, b) for two unsigned operands, one word at a time. Two running
// multiples start at a and b; each cycle the smaller gets its operand added
// by the shared adder until they meet at lcm(a, b). The product a*b is then
// formed and divided by the lcm with a restoring divider that reuses the same
// adder, one quotient bit per cycle. A word with both operands nonzero takes
// S = a/g + b/g - 2 search steps (g the gcd): up to about a + b, near 2^17 for
// 16-bit operands, and this search loop sets the rate. If either operand is
// zero the other is returned with rsp_zero_operand set, and the word goes from
// acceptance straight to the finishing step. req_ready is high only between
// words; a finished result sits in the output register until taken while the
// next word is accepted.
module gcd_by_lcm_search #(
   parameter int unsigned OPERAND_WIDTH = gbl_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_b,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [OPERAND_WIDTH-1:0] rsp_divisor,
   output logic                          rsp_zero_operand
);

   gbl_pkg::ctrl_type   ctrl;
   gbl_pkg::status_type status;

   gbl_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   gbl_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .ctrl             (ctrl),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .status           (status),
      .rsp_divisor      (rsp_divisor),
      .rsp_zero_operand (rsp_zero_operand)
   );

endmodule

`default_nettype wire

>>> rtl/gbl_datapath.sv
// Operand, multiple, product and remainder registers around one shared
// adder/subtractor, plus the result word register. Depends on gbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbl_datapath #(
   parameter int unsigned OPERAND_WIDTH = gbl_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire gbl_pkg::ctrl_type        ctrl,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_b,
   output gbl_pkg::status_type           status,
   output logic      [OPERAND_WIDTH-1:0] rsp_divisor,
   output logic                          rsp_zero_operand
);

   localparam int unsigned WideW = 2 * OPERAND_WIDTH;
   localparam int unsigned SumW  = WideW + 2;

   logic [OPERAND_WIDTH-1:0] x_ff;
   logic [OPERAND_WIDTH-1:0] y_ff;
   logic [WideW-1:0]         mx_ff;
   logic [WideW-1:0]         my_ff;
   logic [WideW-1:0]         rem_ff;
   logic [WideW-1:0]         prod_ff;
   logic                     zero_ff;
   logic [OPERAND_WIDTH-1:0] divisor_ff;
   logic                     zero_out_ff;

   logic                     mx_lt_my;
   logic [WideW:0]           shifted;
   logic [SumW-1:0]          unit_a;
   logic [SumW-1:0]          unit_b;
   logic                     unit_sub;
   logic [SumW-1:0]          unit_sum;
   logic                     fits;

   assign mx_lt_my = (mx_ff < my_ff);
   assign shifted  = {rem_ff, prod_ff[WideW-1]};

   // Shared unit: advance the smaller multiple, or take the trial subtract
   always_comb begin
      if (ctrl.div_step) begin
         unit_a   = {1'b0, shifted};
         unit_b   = {2'b00, mx_ff};
         unit_sub = 1'b1;
      end else begin
         unit_a   = {2'b00, (mx_lt_my ? mx_ff : my_ff)};
         unit_b   = {{(SumW - OPERAND_WIDTH){1'b0}}, (mx_lt_my ? x_ff : y_ff)};
         unit_sub = 1'b0;
      end
   end

   assign unit_sum = unit_a + (unit_b ^ {SumW{unit_sub}}) + SumW'(unit_sub);
   assign fits     = ~unit_sum[SumW-1];

   always_ff @(posedge clock) begin
      if (ctrl.load_operands) begin
         x_ff    <= req_operand_a;
         y_ff    <= req_operand_b;
         mx_ff   <= WideW'(req_operand_a);
         my_ff   <= WideW'(req_operand_b);
         zero_ff <= status.operand_zero;
      end
      if (ctrl.search_step) begin
         if (mx_lt_my) begin
            mx_ff <= unit_sum[WideW-1:0];
         end else begin
            my_ff <= unit_sum[WideW-1:0];
         end
      end
      if (ctrl.mult) begin
         prod_ff <= WideW'(x_ff) * WideW'(y_ff);
         rem_ff  <= '0;
      end
      // Restoring division; quotient bits shift into the product register
      if (ctrl.div_step) begin
         rem_ff  <= fits ? unit_sum[WideW-1:0] : shifted[WideW-1:0];
         prod_ff <= {prod_ff[WideW-2:0], fits};
      end
      if (ctrl.load_rsp) begin
         if (zero_ff) begin
            divisor_ff <= (x_ff == '0) ? y_ff : x_ff;
         end else begin
            divisor_ff <= prod_ff[OPERAND_WIDTH-1:0];
         end
         zero_out_ff <= zero_ff;
      end
   end

   assign status.operand_zero    = (req_operand_a == '0) || (req_operand_b == '0);
   assign status.multiples_equal = (mx_ff == my_ff);
   assign rsp_divisor            = divisor_ff;
   assign rsp_zero_operand       = zero_out_ff;

endmodule

`default_nettype wire

>>> rtl/gbl_ctrl.sv
// Sequencer: walks one word through search, product and division steps
// and owns both handshakes. Depends on gbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbl_ctrl #(
   parameter int unsigned OPERAND_WIDTH = gbl_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire gbl_pkg::status_type status,
   output gbl_pkg::ctrl_type        ctrl
);

   localparam int unsigned StepCount = 2 * OPERAND_WIDTH;
   localparam int unsigned CntW      = $clog2(StepCount);
   localparam logic [CntW-1:0] LastStep = CntW'(StepCount - 1);

   gbl_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbl_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load_operands = 1'b1;
               // A zero operand would never meet; answer straight away
               state_in = status.operand_zero ? gbl_pkg::ST_FINISH : gbl_pkg::ST_SEARCH;
            end
         end
         gbl_pkg::ST_SEARCH: begin
            if (status.multiples_equal) begin
               state_in = gbl_pkg::ST_MULT;
            end else begin
               ctrl.search_step = 1'b1;
            end
         end
         gbl_pkg::ST_MULT: begin
            ctrl.mult = 1'b1;
            cnt_in    = '0;
            state_in  = gbl_pkg::ST_DIVIDE;
         end
         gbl_pkg::ST_DIVIDE: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               state_in = gbl_pkg::ST_FINISH;
            end
         end
         gbl_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_rsp = 1'b1;
               state_in      = gbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/gbl_checker.sv
// Port-level checks for the GCD-by-LCM-search block, bound to its top level.
// Depends on gcd_by_lcm_search and gbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbl_checker #(
   parameter int unsigned OPERAND_WIDTH = gbl_pkg::OPERAND_WIDTH_DEFAULT
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic [OPERAND_WIDTH-1:0] req_operand_a,
   input wire logic [OPERAND_WIDTH-1:0] req_operand_b,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [OPERAND_WIDTH-1:0] rsp_divisor,
   input wire logic                     rsp_zero_operand
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_divisor)
         && $stable(rsp_zero_operand))
      else $error("result word changed while stalled");

   // Busy right after a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while a word is in flight");

   // A new result only comes from the finishing step, never while idle
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in flight");

   // GCD of two nonzero operands is nonzero
   a_nonzero_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_operand |-> rsp_divisor != '0)
      else $error("zero divisor without zero operand");

endmodule

bind gcd_by_lcm_search gbl_checker #(
   .OPERAND_WIDTH(OPERAND_WIDTH)
) u_gbl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operand_a    (req_operand_a),
   .req_operand_b    (req_operand_b),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_divisor      (rsp_divisor),
   .rsp_zero_operand (rsp_zero_operand)
);

`default_nettype wire
